### rtl/scpe_pkg.sv
package scpe_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int COL_W        = 7;
    localparam int ROW_W        = 8;
    localparam int PLOT_COLUMNS = 128;
    localparam int ROW_SPAN     = 127;
    localparam int NUM_W        = SAMPLE_W + 7;
    localparam int DIV_STEPS    = NUM_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    localparam logic [ROW_W-1:0] ROW_TOP    = 8'd32;
    localparam logic [ROW_W-1:0] ROW_BOTTOM = 8'd159;
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(PLOT_COLUMNS - 1);

    localparam logic [2:0] ACT_POINT   = 3'd0;
    localparam logic [2:0] ACT_LINE    = 3'd1;
    localparam logic [2:0] ACT_BAR     = 3'd2;
    localparam logic [2:0] ACT_NEXT    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;

    localparam logic [1:0] REG_PLOT_LOW  = 2'd0;
    localparam logic [1:0] REG_PLOT_HIGH = 2'd1;

    localparam logic signed [SAMPLE_W-1:0] PLOT_LOW_RST  = 32'sd0;
    localparam logic signed [SAMPLE_W-1:0] PLOT_HIGH_RST = 32'sd4095;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

endpackage

### rtl/scpe_if.sv
interface scpe_in_if import scpe_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [2:0]                 action;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, action, sample, input ready);
    modport sink   (input valid, action, sample, output ready);
endinterface

interface scpe_out_if import scpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             draw;
    logic [COL_W-1:0] column;
    logic [1:0]       span_width;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
    logic             colour_select;
    logic             bad_range;

    modport source (output valid, draw, column, span_width, row_first, row_last,
                    colour_select, bad_range, input ready);
    modport sink   (input valid, draw, column, span_width, row_first, row_last,
                    colour_select, bad_range, output ready);
endinterface

interface scpe_cfg_if import scpe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          index;
    logic [SAMPLE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/strip_chart_plot_engine.sv
// Steps: a point, line or bar item goes through clamp, difference, times-127,
// 39 bit-serial divide steps and finish, where its result is registered; items that skip
// the divide (other actions, or a bad range) go from clamp straight to finish.
// Flow: one item at a time, taken only in idle; finish waits while the output register is
// full and not taken. A bit-serial restoring divider scales the sample to a row.
// Reset (synchronous, active low): column and last row to zero, plot_low 0, plot_high 4095,
// output register empty.
module strip_chart_plot_engine import scpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scpe_in_if.sink            i_in,
    scpe_out_if.source         o_out,
    scpe_cfg_if.sink           i_cfg
);

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_plot_low, n_plot_low;
    logic signed [SAMPLE_W-1:0] r_plot_high, n_plot_high;
    logic [COL_W-1:0]           r_col, n_col;
    logic [ROW_W-1:0]           r_last_row, n_last_row;

    logic [2:0]                 r_action, n_action;
    logic signed [SAMPLE_W-1:0] r_v, n_v;
    logic [SAMPLE_W-1:0]        r_den, n_den;
    logic [SAMPLE_W-1:0]        r_rem, n_rem;
    logic [NUM_W-1:0]           r_num, n_num;
    logic [CNT_W-1:0]           r_cnt, n_cnt;

    logic             r_ovalid, n_ovalid;
    logic             r_draw, n_draw;
    logic [COL_W-1:0] r_ocol, n_ocol;
    logic [1:0]       r_width, n_width;
    logic [ROW_W-1:0] r_first, n_first;
    logic [ROW_W-1:0] r_last, n_last;
    logic             r_colour, n_colour;
    logic             r_bad, n_bad;

    logic                 bad;
    logic                 plot_act;
    logic [SAMPLE_W:0]    diff_d;
    logic [SAMPLE_W:0]    diff_den;
    logic [SAMPLE_W:0]    rem_sh;
    logic [SAMPLE_W:0]    rem_sub;
    logic [ROW_W-1:0]     row;
    logic [ROW_W-1:0]     prev;
    logic [1:0]           wide;
    logic                 slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plot_low  <= PLOT_LOW_RST;
            r_plot_high <= PLOT_HIGH_RST;
            r_col       <= '0;
            r_last_row  <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_plot_low  <= n_plot_low;
            r_plot_high <= n_plot_high;
            r_col       <= n_col;
            r_last_row  <= n_last_row;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_v      <= n_v;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_num    <= n_num;
        r_cnt    <= n_cnt;
        r_draw   <= n_draw;
        r_ocol   <= n_ocol;
        r_width  <= n_width;
        r_first  <= n_first;
        r_last   <= n_last;
        r_colour <= n_colour;
        r_bad    <= n_bad;
    end

    assign bad      = !(r_plot_high > r_plot_low);
    assign plot_act = (r_action == ACT_POINT) || (r_action == ACT_LINE) ||
                      (r_action == ACT_BAR);

    assign diff_d   = {r_plot_high[SAMPLE_W-1], r_plot_high} - {r_v[SAMPLE_W-1], r_v};
    assign diff_den = {r_plot_high[SAMPLE_W-1], r_plot_high} -
                      {r_plot_low[SAMPLE_W-1], r_plot_low};

    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // quotient never exceeds 127 because the clamped sample keeps d <= den
    assign row  = ROW_TOP + {1'b0, r_num[6:0]};
    assign prev = (r_last_row < ROW_TOP || r_last_row > ROW_BOTTOM) ? row : r_last_row;
    assign wide = (r_col == COL_LAST) ? 2'd1 : 2'd2;

    assign slot_free = !r_ovalid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_ovalid;
    assign o_out.draw          = r_draw;
    assign o_out.column        = r_ocol;
    assign o_out.span_width    = r_width;
    assign o_out.row_first     = r_first;
    assign o_out.row_last      = r_last;
    assign o_out.colour_select = r_colour;
    assign o_out.bad_range     = r_bad;

    always_comb begin
        n_state     = r_state;
        n_plot_low  = r_plot_low;
        n_plot_high = r_plot_high;
        n_col       = r_col;
        n_last_row  = r_last_row;
        n_action    = r_action;
        n_v         = r_v;
        n_den       = r_den;
        n_rem       = r_rem;
        n_num       = r_num;
        n_cnt       = r_cnt;
        n_ovalid    = r_ovalid;
        n_draw      = r_draw;
        n_ocol      = r_ocol;
        n_width     = r_width;
        n_first     = r_first;
        n_last      = r_last;
        n_colour    = r_colour;
        n_bad       = r_bad;

        if (i_cfg.valid) begin
            if (i_cfg.index == REG_PLOT_LOW) begin
                n_plot_low = i_cfg.data;
            end else if (i_cfg.index == REG_PLOT_HIGH) begin
                n_plot_high = i_cfg.data;
            end
        end

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action = i_in.action;
                    n_v      = i_in.sample;
                    n_state  = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (plot_act && !bad) begin
                    if (r_v < r_plot_low) begin
                        n_v = r_plot_low;
                    end else if (r_v > r_plot_high) begin
                        n_v = r_plot_high;
                    end
                    n_state = S_DIFF;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIFF: begin
                n_num   = {7'd0, diff_d[SAMPLE_W-1:0]};
                n_den   = diff_den[SAMPLE_W-1:0];
                n_state = S_MUL;
            end
            S_MUL: begin
                // times 127 as times 128 minus one
                n_num   = {r_num[SAMPLE_W-1:0], 7'd0} - r_num;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // shift one numerator bit into the remainder, shift one quotient bit into the numerator
                if (!rem_sub[SAMPLE_W]) begin
                    n_rem = rem_sub[SAMPLE_W-1:0];
                    n_num = {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[SAMPLE_W-1:0];
                    n_num = {r_num[NUM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_bad    = bad;
                    n_draw   = 1'b0;
                    n_ocol   = '0;
                    n_width  = '0;
                    n_first  = '0;
                    n_last   = '0;
                    n_colour = 1'b0;
                    n_state  = S_IDLE;
                    if (plot_act && !bad) begin
                        case (r_action)
                            ACT_POINT: begin
                                n_draw  = 1'b1;
                                n_ocol  = r_col;
                                n_width = wide;
                                n_first = row;
                                n_last  = (row == ROW_BOTTOM) ? row : row + 1'b1;
                            end
                            ACT_LINE: begin
                                n_draw  = 1'b1;
                                n_ocol  = r_col;
                                n_width = wide;
                                if (prev < row) begin
                                    n_first = prev + 1'b1;
                                    n_last  = row;
                                end else if (prev > row) begin
                                    n_first = row;
                                    n_last  = prev - 1'b1;
                                end else begin
                                    n_first = row;
                                    n_last  = row;
                                end
                                n_last_row = row;
                            end
                            default: begin
                                if (row < ROW_BOTTOM) begin
                                    n_draw   = 1'b1;
                                    n_ocol   = r_col;
                                    n_width  = 2'd1;
                                    n_first  = row;
                                    n_last   = ROW_BOTTOM - 1'b1;
                                    n_colour = 1'b1;
                                end
                            end
                        endcase
                    end else if (r_action == ACT_NEXT) begin
                        n_col = (r_col == COL_LAST) ? '0 : r_col + 1'b1;
                    end else if (r_action == ACT_RESTART) begin
                        n_col = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import scpe_pkg::*;

    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic             draw;
        logic [COL_W-1:0] column;
        logic [1:0]       span_width;
        logic [ROW_W-1:0] row_first;
        logic [ROW_W-1:0] row_last;
        logic             colour_select;
        logic             bad_range;
    } t_span;

    typedef enum logic {STEP_ITEM, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [2:0]  action;
        logic [31:0] value;
        logic [1:0]  index;
        bit          pinned;
        t_span       span;
    } t_plan_row;

    localparam t_span SPAN_NONE = '0;
    localparam t_span SPAN_BAD  = '{1'b0, 7'd0, 2'd0, 8'd0, 8'd0, 1'b0, 1'b1};
    localparam t_span SPAN_TOP_DOT =
        '{1'b1, 7'd0, 2'd2, ROW_TOP, ROW_TOP + 8'd1, 1'b0, 1'b0};
    localparam t_span SPAN_BOTTOM_DOT =
        '{1'b1, 7'd0, 2'd2, ROW_BOTTOM, ROW_BOTTOM, 1'b0, 1'b0};
    localparam t_span SPAN_FULL_BAR =
        '{1'b1, 7'd0, 2'd1, ROW_TOP, ROW_BOTTOM - 8'd1, 1'b1, 1'b0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    scpe_in_if  item_bus ();
    scpe_out_if span_bus ();
    scpe_cfg_if reg_bus ();

    strip_chart_plot_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_bus),
        .o_out   (span_bus),
        .i_cfg   (reg_bus)
    );

    always #2 i_clk = ~i_clk;

    // Plotter state as the block should hold it
    logic signed [31:0] plot_low   = PLOT_LOW_RST;
    logic signed [31:0] plot_high  = PLOT_HIGH_RST;
    logic [COL_W-1:0]   cur_column = '0;
    logic [ROW_W-1:0]   last_row   = '0;

    t_span span_queue[$];
    int    mismatch_count = 0;
    bit    quiet_run = 1'b0;

    t_plan_row plan[$] = '{
        '{STEP_ITEM,  ACT_POINT,   32'd4095,         REG_PLOT_LOW,  1'b1, SPAN_TOP_DOT},
        '{STEP_ITEM,  ACT_POINT,   32'd0,            REG_PLOT_LOW,  1'b1, SPAN_BOTTOM_DOT},
        '{STEP_ITEM,  ACT_POINT,   32'h8000_0000,    REG_PLOT_LOW,  1'b1, SPAN_BOTTOM_DOT},
        '{STEP_ITEM,  ACT_POINT,   32'h7fff_ffff,    REG_PLOT_LOW,  1'b1, SPAN_TOP_DOT},
        '{STEP_ITEM,  ACT_LINE,    32'd2048,         REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_LINE,    32'd4095,         REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_LINE,    32'd0,            REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_BAR,     32'd0,            REG_PLOT_LOW,  1'b1, SPAN_NONE},
        '{STEP_ITEM,  ACT_BAR,     32'd4095,         REG_PLOT_LOW,  1'b1, SPAN_FULL_BAR},
        '{STEP_ITEM,  ACT_BAR,     32'd1000,         REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_NEXT,    32'd77,           REG_PLOT_LOW,  1'b1, SPAN_NONE},
        '{STEP_ITEM,  ACT_POINT,   32'd3000,         REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_RSVD5,   32'd100,          REG_PLOT_LOW,  1'b1, SPAN_NONE},
        '{STEP_ITEM,  ACT_RSVD6,   32'hffff_ffff,    REG_PLOT_LOW,  1'b1, SPAN_NONE},
        '{STEP_ITEM,  ACT_RSVD7,   32'd2000,         REG_PLOT_LOW,  1'b1, SPAN_NONE},
        '{STEP_ITEM,  ACT_RESTART, 32'd5,            REG_PLOT_LOW,  1'b1, SPAN_NONE},
        '{STEP_WRITE, ACT_POINT,   32'h5a5a_a5a5,    REG_SPARE,     1'b0, SPAN_NONE},
        '{STEP_WRITE, ACT_POINT,   32'h8000_0000,    REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_WRITE, ACT_POINT,   32'h7fff_ffff,    REG_PLOT_HIGH, 1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_POINT,   32'd0,            REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_LINE,    32'h8000_0000,    REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_BAR,     32'h7fff_ffff,    REG_PLOT_LOW,  1'b1, SPAN_FULL_BAR},
        '{STEP_WRITE, ACT_POINT,   32'd5,            REG_PLOT_LOW,  1'b0, SPAN_NONE},
        '{STEP_WRITE, ACT_POINT,   32'd5,            REG_PLOT_HIGH, 1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_POINT,   32'd7,            REG_PLOT_LOW,  1'b1, SPAN_BAD},
        '{STEP_ITEM,  ACT_LINE,    32'd5,            REG_PLOT_LOW,  1'b1, SPAN_BAD},
        '{STEP_ITEM,  ACT_BAR,     32'd0,            REG_PLOT_LOW,  1'b1, SPAN_BAD},
        '{STEP_ITEM,  ACT_NEXT,    32'd0,            REG_PLOT_LOW,  1'b1, SPAN_BAD},
        '{STEP_ITEM,  ACT_RESTART, 32'd0,            REG_PLOT_LOW,  1'b1, SPAN_BAD},
        '{STEP_WRITE, ACT_POINT,   32'd4,            REG_PLOT_HIGH, 1'b0, SPAN_NONE},
        '{STEP_ITEM,  ACT_POINT,   32'd4,            REG_PLOT_LOW,  1'b1, SPAN_BAD}
    };

    function automatic t_span plot_span(logic [2:0] act, logic signed [31:0] smp);
        t_span        res;
        logic         bad;
        logic [1:0]   wide;
        longint       lo, hi, v, q;
        logic [ROW_W-1:0] row, prev;
        res  = '0;
        bad  = !(plot_high > plot_low);
        wide = (cur_column == COL_LAST) ? 2'd1 : 2'd2;
        if (act <= ACT_BAR && !bad) begin
            lo = plot_low;
            hi = plot_high;
            v  = smp;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            q = longint'(ROW_TOP) + (longint'(ROW_SPAN) * (hi - v)) / (hi - lo);
            if (q < longint'(ROW_TOP)) q = longint'(ROW_TOP);
            if (q > longint'(ROW_BOTTOM)) q = longint'(ROW_BOTTOM);
            row = q[ROW_W-1:0];
            res.column = cur_column;
            case (act)
                ACT_POINT: begin
                    res.draw       = 1'b1;
                    res.span_width = wide;
                    res.row_first  = row;
                    res.row_last   = (row == ROW_BOTTOM) ? row : row + 8'd1;
                end
                ACT_LINE: begin
                    // a row outside the plot means nothing drawn yet
                    prev = (last_row < ROW_TOP || last_row > ROW_BOTTOM) ? row : last_row;
                    res.draw       = 1'b1;
                    res.span_width = wide;
                    if (prev < row) begin
                        res.row_first = prev + 8'd1;
                        res.row_last  = row;
                    end else if (prev > row) begin
                        res.row_first = row;
                        res.row_last  = prev - 8'd1;
                    end else begin
                        res.row_first = row;
                        res.row_last  = row;
                    end
                    last_row = row;
                end
                ACT_BAR: begin
                    if (row < ROW_BOTTOM) begin
                        res.draw          = 1'b1;
                        res.span_width    = 2'd1;
                        res.colour_select = 1'b1;
                        res.row_first     = row;
                        res.row_last      = ROW_BOTTOM - 8'd1;
                    end
                end
                default: ;
            endcase
            if (!res.draw) res.column = '0;
        end else if (act == ACT_NEXT) begin
            cur_column = (cur_column == COL_LAST) ? '0 : cur_column + 1'b1;
        end else if (act == ACT_RESTART) begin
            cur_column = '0;
        end
        res.bad_range = bad;
        return res;
    endfunction

    function automatic logic [2:0] pick_action(bit drawing_only);
        int r;
        r = drawing_only ? $urandom_range(74) : $urandom_range(99);
        if (r < 30) return ACT_POINT;
        if (r < 55) return ACT_LINE;
        if (r < 75) return ACT_BAR;
        if (r < 85) return ACT_NEXT;
        if (r < 92) return ACT_RESTART;
        case ($urandom_range(2))
            0:       return ACT_RSVD5;
            1:       return ACT_RSVD6;
            default: return ACT_RSVD7;
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        longint range;
        longint v;
        int     sel;
        range = longint'(plot_high) - longint'(plot_low);
        sel   = $urandom_range(9);
        if (sel < 6 && range >= 0)
            v = longint'(plot_low) + longint'($urandom) % (range + 1);
        else if (sel == 6)
            v = longint'(plot_low) - $urandom_range(3);
        else if (sel == 7)
            v = longint'(plot_high) + $urandom_range(3);
        else if (sel == 8)
            v = $urandom_range(1) ? longint'(32'sh7fff_ffff) : longint'(32'sh8000_0000);
        else
            v = longint'($urandom);
        return v[31:0];
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic send_item(input logic [2:0] act, input logic [31:0] smp,
                             input bit pinned, input t_span pinned_span);
        t_span pred;
        if (!item_bus.valid) item_bus.valid <= 1'b1;
        item_bus.action <= act;
        item_bus.sample <= smp;
        do @(posedge i_clk); while (!item_bus.ready);
        pred = plot_span(act, smp);
        span_queue.push_back(pinned ? pinned_span : pred);
    endtask

    task automatic sender_pause();
        int n;
        if (!quiet_run && $urandom_range(99) < 34) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
            item_bus.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off new items until every span has come out
    task automatic drain_spans();
        if (item_bus.valid) item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (span_queue.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= val;
        do @(posedge i_clk); while (!reg_bus.ready);
        if (idx == REG_PLOT_LOW) plot_low = val;
        else if (idx == REG_PLOT_HIGH) plot_high = val;
        reg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic signed [31:0] lo, input logic signed [31:0] hi,
                             input int count);
        drain_spans();
        write_reg(REG_PLOT_LOW, lo);
        write_reg(REG_PLOT_HIGH, hi);
        repeat (count) begin
            send_item(pick_action(1'b0), pick_sample(), 1'b0, SPAN_NONE);
            sender_pause();
        end
    endtask

    always @(posedge i_clk) begin
        span_bus.ready <= quiet_run || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && span_bus.valid && span_bus.ready) begin
            if (span_queue.size() == 0) begin
                $error("span transfer with no expected result");
                mismatch_count++;
            end else begin
                want = span_queue.pop_front();
                check_field("draw", want.draw, span_bus.draw);
                check_field("column", want.column, span_bus.column);
                check_field("span_width", want.span_width, span_bus.span_width);
                check_field("row_first", want.row_first, span_bus.row_first);
                check_field("row_last", want.row_last, span_bus.row_last);
                check_field("colour_select", want.colour_select, span_bus.colour_select);
                check_field("bad_range", want.bad_range, span_bus.bad_range);
            end
        end
    end

    initial begin
        logic signed [31:0] a, b, t;
        item_bus.valid  <= 1'b0;
        item_bus.action <= ACT_POINT;
        item_bus.sample <= '0;
        reg_bus.valid   <= 1'b0;
        reg_bus.index   <= REG_PLOT_LOW;
        reg_bus.data    <= '0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == STEP_WRITE) begin
                drain_spans();
                write_reg(plan[k].index, plan[k].value);
            end else begin
                send_item(plan[k].action, plan[k].value, plan[k].pinned, plan[k].span);
                sender_pause();
            end
        end

        // Sweep every column through the wrap, drawing once per column
        drain_spans();
        write_reg(REG_PLOT_LOW, PLOT_LOW_RST);
        write_reg(REG_PLOT_HIGH, PLOT_HIGH_RST);
        send_item(ACT_RESTART, $urandom, 1'b0, SPAN_NONE);
        for (int c = 0; c < PLOT_COLUMNS; c++) begin
            quiet_run = (c < 40);
            send_item(ACT_NEXT, $urandom, 1'b0, SPAN_NONE);
            sender_pause();
            send_item(pick_action(1'b1), pick_sample(), 1'b0, SPAN_NONE);
            sender_pause();
        end
        quiet_run = 1'b0;

        run_phase(32'sh8000_0000, 32'sh7fff_ffff, 30);
        run_phase(32'sd0, 32'sd1, 20);
        run_phase(-32'sd1000, -32'sd10, 20);
        repeat (2) begin
            a = $urandom;
            b = $urandom;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            run_phase(a, b, 30);
        end
        run_phase(32'sd7, 32'sd7, 10);
        run_phase(32'sd100, 32'sd50, 8);
        run_phase(PLOT_LOW_RST, PLOT_HIGH_RST, 20);

        drain_spans();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
